FILE: rtl/gmms_pkg.sv
// Shared types and constants for the grid maze minimum-steps unit.
`default_nettype none

package gmms_pkg;

   // Request kinds carried in req_tuser
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   // Width used for bounds arithmetic on coordinates (covers 4-bit fields and up to 64)
   localparam int COORD_W = 7;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 5;
   localparam logic CSR_IDX_ROWS = 1'b0;
   localparam logic CSR_IDX_COLS = 1'b1;

   // Stream word layout
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int FIELD_W    = 4;
   localparam int STEPS_W    = 8;

   // Neighbor directions, probed in this order
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load_write;
      logic solve_latch;
      logic clear_step;
      logic seed;
      logic pop;
      logic probe;
      logic next_dir;
      logic mark;
      logic out_load;
      logic out_found;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic start_out;
      logic same_cell;
      logic end_out;
      logic clear_last;
      logic queue_empty;
      logic nb_ok;
      logic nb_free;
      logic nb_target;
      logic dir_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/gmms_ctrl.sv
// Sequencer for loads and the breadth-first wavefront search.
`default_nettype none

module gmms_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_solve,
   output logic                   req_ready,
   output gmms_pkg::ctrl_cmd_type cmd,
   input  gmms_pkg::dp_status_type status
);
   import gmms_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_SEED  = 7'b0000100,
      ST_POP   = 7'b0001000,
      ST_PROBE = 7'b0010000,
      ST_EVAL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   // Next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      found_in  = found_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_solve != REQ_SOLVE) begin
                  cmd.load_write = 1'b1;
               end else begin
                  cmd.solve_latch = 1'b1;
                  priority if (status.start_out) begin
                     found_in = 1'b0;
                     state_in = ST_DONE;
                  end else if (status.same_cell) begin
                     found_in = 1'b1;
                     state_in = ST_DONE;
                  end else if (status.end_out) begin
                     found_in = 1'b0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (status.queue_empty) begin
               found_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.nb_ok) begin
               cmd.probe = 1'b1;
               state_in  = ST_EVAL;
            end else if (status.dir_last) begin
               state_in = ST_POP;
            end else begin
               cmd.next_dir = 1'b1;
            end
         end
         ST_EVAL: begin
            if (status.nb_free && status.nb_target) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.mark = status.nb_free;
               if (status.dir_last) begin
                  state_in = ST_POP;
               end else begin
                  cmd.next_dir = 1'b1;
                  state_in     = ST_PROBE;
               end
            end
         end
         ST_DONE: begin
            // Wait for the output register to free up
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_found = found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gmms_datapath.sv
// Grid stores, frontier queue, neighbor generation and result register.
`default_nettype none

module gmms_datapath #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  gmms_pkg::ctrl_cmd_type               cmd,
   output gmms_pkg::dp_status_type              status,
   input  wire [gmms_pkg::CFG_W-1:0]            grid_rows,
   input  wire [gmms_pkg::CFG_W-1:0]            grid_cols,
   input  wire [gmms_pkg::REQ_DATA_W-1:0]       req_data,
   input  wire                                  rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [gmms_pkg::STEPS_W-1:0]         rsp_steps
);
   import gmms_pkg::*;

   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLS);
   localparam int AB    = RB + CB;
   localparam int DEPTH = 1 << AB;
   localparam int DW    = $clog2(DEPTH + 1);
   localparam int SW    = (DW > STEPS_W) ? DW : STEPS_W;

   // Request fields
   logic [FIELD_W-1:0] f_cell_row, f_cell_col, f_start_row, f_start_col, f_end_row, f_end_col;
   logic               f_blocked;
   assign f_cell_row  = req_data[3:0];
   assign f_cell_col  = req_data[7:4];
   assign f_blocked   = req_data[8];
   assign f_start_row = req_data[12:9];
   assign f_start_col = req_data[16:13];
   assign f_end_row   = req_data[20:17];
   assign f_end_col   = req_data[24:21];

   // Extended coordinates and grid size in use
   logic [COORD_W-1:0] cr_x, cc_x, sr_x, sc_x, er_x, ec_x, eff_rows, eff_cols;
   assign cr_x = COORD_W'(f_cell_row);
   assign cc_x = COORD_W'(f_cell_col);
   assign sr_x = COORD_W'(f_start_row);
   assign sc_x = COORD_W'(f_start_col);
   assign er_x = COORD_W'(f_end_row);
   assign ec_x = COORD_W'(f_end_col);
   assign eff_rows = (COORD_W'(grid_rows) > COORD_W'(MAX_ROWS)) ? COORD_W'(MAX_ROWS)
                                                                 : COORD_W'(grid_rows);
   assign eff_cols = (COORD_W'(grid_cols) > COORD_W'(MAX_COLS)) ? COORD_W'(MAX_COLS)
                                                                 : COORD_W'(grid_cols);

   logic          load_in_range;
   logic [AB-1:0] load_addr;
   assign load_in_range = (cr_x < COORD_W'(MAX_ROWS)) && (cc_x < COORD_W'(MAX_COLS));
   assign load_addr     = {cr_x[RB-1:0], cc_x[CB-1:0]};

   // Search registers
   logic [AB-1:0]      start_addr_ff, end_addr_ff, clr_ff, ni_ff, q_rd_ff;
   logic [COORD_W-1:0] rows_ff, cols_ff;
   logic [AB:0]        head_ff, tail_ff, level_end_ff;
   logic [DW-1:0]      dist_ff;
   logic [1:0]         dir_ff;
   logic               blk_rd_ff, vis_rd_ff;

   // Memories
   logic blocked_mem [DEPTH];
   logic visited_mem [DEPTH];
   logic [AB-1:0] queue_mem [DEPTH];

   // Neighbor of the current cell in the current direction
   logic [COORD_W-1:0] cur_r, cur_c, nb_r, nb_c;
   logic               nb_ok;
   logic [AB-1:0]      nb_addr;
   always_comb begin
      cur_r = COORD_W'(q_rd_ff[AB-1:CB]);
      cur_c = COORD_W'(q_rd_ff[CB-1:0]);
      nb_r  = cur_r;
      nb_c  = cur_c;
      nb_ok = 1'b0;
      unique case (dir_ff)
         DIR_UP: begin
            nb_r  = cur_r - COORD_W'(1);
            nb_ok = cur_r != '0;
         end
         DIR_DOWN: begin
            nb_r  = cur_r + COORD_W'(1);
            nb_ok = nb_r < rows_ff;
         end
         DIR_LEFT: begin
            nb_c  = cur_c - COORD_W'(1);
            nb_ok = cur_c != '0;
         end
         DIR_RIGHT: begin
            nb_c  = cur_c + COORD_W'(1);
            nb_ok = nb_c < cols_ff;
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
      nb_addr = {nb_r[RB-1:0], nb_c[CB-1:0]};
   end

   // Status back to the controller
   always_comb begin
      status             = '0;
      status.start_out   = (sr_x >= eff_rows) || (sc_x >= eff_cols);
      status.same_cell   = (f_start_row == f_end_row) && (f_start_col == f_end_col);
      status.end_out     = (er_x >= eff_rows) || (ec_x >= eff_cols);
      status.clear_last  = &clr_ff;
      status.queue_empty = head_ff == tail_ff;
      status.nb_ok       = nb_ok;
      status.nb_free     = !blk_rd_ff && !vis_rd_ff;
      status.nb_target   = ni_ff == end_addr_ff;
      status.dir_last    = dir_ff == DIR_RIGHT;
      status.out_free    = !rsp_valid || rsp_ready;
   end

   // Obstacle store: write on load, read on probe
   always_ff @(posedge clock) begin
      if (cmd.load_write && load_in_range) begin
         blocked_mem[load_addr] <= f_blocked;
      end
      if (cmd.probe) begin
         blk_rd_ff <= blocked_mem[nb_addr];
      end
   end

   // Visited store: clear sweep, seed, mark; read on probe
   logic          vis_we, vis_wd;
   logic [AB-1:0] vis_wa;
   always_comb begin
      vis_we = cmd.clear_step || cmd.seed || cmd.mark;
      vis_wd = !cmd.clear_step;
      priority if (cmd.clear_step) begin
         vis_wa = clr_ff;
      end else if (cmd.seed) begin
         vis_wa = start_addr_ff;
      end else begin
         vis_wa = ni_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_mem[vis_wa] <= vis_wd;
      end
      if (cmd.probe) begin
         vis_rd_ff <= visited_mem[nb_addr];
      end
   end

   // Frontier queue: push at tail, pop at head
   always_ff @(posedge clock) begin
      if (cmd.seed) begin
         queue_mem[0] <= start_addr_ff;
      end else if (cmd.mark) begin
         queue_mem[tail_ff[AB-1:0]] <= ni_ff;
      end
      if (cmd.pop) begin
         q_rd_ff <= queue_mem[head_ff[AB-1:0]];
      end
   end

   // Search bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         level_end_ff <= '0;
         dist_ff      <= '0;
         dir_ff       <= DIR_UP;
      end else begin
         if (cmd.solve_latch) begin
            clr_ff  <= '0;
            dist_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_ff <= clr_ff + AB'(1);
         end
         if (cmd.seed) begin
            head_ff      <= '0;
            tail_ff      <= (AB + 1)'(1);
            level_end_ff <= '0;
            dist_ff      <= '0;
         end else begin
            if (cmd.pop) begin
               head_ff <= head_ff + (AB + 1)'(1);
               // Start of a new wave: advance the level boundary
               if (head_ff == level_end_ff) begin
                  level_end_ff <= tail_ff;
                  dist_ff      <= dist_ff + DW'(1);
               end
            end
            if (cmd.mark) begin
               tail_ff <= tail_ff + (AB + 1)'(1);
            end
         end
         if (cmd.pop) begin
            dir_ff <= DIR_UP;
         end else if (cmd.next_dir) begin
            dir_ff <= dir_ff + 2'd1;
         end
      end
   end

   // Solve operands and probed neighbor
   always_ff @(posedge clock) begin
      if (cmd.solve_latch) begin
         start_addr_ff <= {sr_x[RB-1:0], sc_x[CB-1:0]};
         end_addr_ff   <= {er_x[RB-1:0], ec_x[CB-1:0]};
         rows_ff       <= eff_rows;
         cols_ff       <= eff_cols;
      end
      if (cmd.probe) begin
         ni_ff <= nb_addr;
      end
   end

   // Result register, saturating the distance
   logic [SW-1:0]      dist_w;
   logic [STEPS_W-1:0] steps_sat;
   assign dist_w    = SW'(dist_ff);
   assign steps_sat = (dist_w > SW'(255)) ? STEPS_W'(255) : dist_w[STEPS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found <= cmd.out_found;
         rsp_steps <= cmd.out_found ? steps_sat : '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/grid_maze_min_steps_unit.sv
// Top level of the grid maze minimum-steps unit: ports, registers, controller and datapath.
//
// Usage: the request stream carries two kinds of words, picked by req_tuser[0].
// A load word (0) writes one grid cell as open or blocked; loads stream at one
// word per cycle while no solve is running. A solve word (1) names a start and an end
// cell and yields one response word: rsp_tuser[0] is found, rsp_tdata the
// fewest four-neighbour moves (0 when not found, saturating at 255).
// Solve sequence: trivial cases (start outside the grid, start equal to end, end
// outside) skip the search. Otherwise acceptance is followed by a sweep
// of the visited store, one entry per cycle over 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
// entries (256 at the default size), seeding of the queue, a dequeue per cell plus
// a final check when the queue runs empty, a skip for each direction out of the
// grid and a probe and an evaluation for each direction inside it (one memory read
// port per store), and posting of the result. req_tready is low while a solve runs.
// The result sits in an output register; while it waits for rsp_tready the
// block keeps accepting loads and may run the next solve, holding its answer
// until the register frees. Reset clears the controller, drops any pending
// response and sets grid_rows and grid_cols to 16; the cell store keeps
// undefined contents until loaded.
`default_nettype none

module grid_maze_min_steps_unit #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request word
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // tdata: cell_row[3:0], cell_col[7:4], cell_blocked[8], start_row[12:9],
   //        start_col[16:13], end_row[20:17], end_col[24:21], zero[31:25]
   input  wire [gmms_pkg::REQ_DATA_W-1:0]        req_tdata,
   // tuser: req_type[0]
   input  wire [0:0]                             req_tuser,
   // Response word
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // tdata: min_steps[7:0]
   output logic [gmms_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: found[0]
   output logic [0:0]                            rsp_tuser,
   // Register port
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire [gmms_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire [gmms_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [gmms_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import gmms_pkg::*;

   logic [CFG_W-1:0] grid_rows_ff, grid_cols_ff;
   logic             csr_write;
   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic             rsp_found;

   // Register writes and reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CFG_W'(16);
         grid_cols_ff <= CFG_W'(16);
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_ROWS) begin
            grid_rows_ff <= csr_pwdata[CFG_W-1:0];
         end else begin
            grid_cols_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_ROWS: csr_prdata = CSR_DATA_W'(grid_rows_ff);
         CSR_IDX_COLS: csr_prdata = CSR_DATA_W'(grid_cols_ff);
         default:      csr_prdata = '0;
      endcase
   end

   gmms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_solve (req_tuser[0]),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   gmms_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .grid_rows (grid_rows_ff),
      .grid_cols (grid_cols_ff),
      .req_data  (req_tdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_found (rsp_found),
      .rsp_steps (rsp_tdata)
   );

   assign rsp_tuser = rsp_found;

`ifndef SYNTHESIS
   // A search holds off the next request word
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == REQ_SOLVE) |=> !req_tready)
      else $error("request accepted right after a solve word");

   // An unreachable answer carries zero steps
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero steps with found low");

   // A row register write lands
   a_rows_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_paddr[2] == CSR_IDX_ROWS) |=>
         (grid_rows_ff == $past(csr_pwdata[CFG_W-1:0])))
      else $error("grid_rows write lost");
`endif

endmodule

`default_nettype wire
